// File: sv/a2b_pkg.sv
// Shared types, code tables and the character mapping function for the
// ASCII to ITA2 Baudot encoder. No dependencies.

package a2b_pkg;

    typedef logic [7:0] char_t;
    typedef logic [4:0] code_t;
    typedef logic [1:0] shift_t;

    // Shift states
    localparam shift_t SH_UNKNOWN = 2'd0;
    localparam shift_t SH_LETTERS = 2'd1;
    localparam shift_t SH_FIGURES = 2'd2;

    // Shift codes and case-free codes
    localparam code_t CODE_LTRS  = 5'd31;
    localparam code_t CODE_FIGS  = 5'd27;
    localparam code_t CODE_SPACE = 5'd4;
    localparam code_t CODE_CR    = 5'd2;
    localparam code_t CODE_LF    = 5'd8;
    localparam code_t CODE_NONE  = 5'd0;

    localparam code_t DIGIT_CODES [10] = '{
        5'd22, 5'd23, 5'd19, 5'd1, 5'd10, 5'd16, 5'd21, 5'd7, 5'd6, 5'd24
    };

    localparam code_t ALPHA_CODES [26] = '{
        5'd3,  5'd25, 5'd14, 5'd9,  5'd1,  5'd13, 5'd26, 5'd20, 5'd6,
        5'd11, 5'd15, 5'd18, 5'd28, 5'd12, 5'd24, 5'd22, 5'd23, 5'd10,
        5'd5,  5'd16, 5'd7,  5'd30, 5'd19, 5'd29, 5'd21, 5'd17
    };

    // Character lookup: code, whether it needs a case, and which case
    typedef struct packed {
        logic   cased;
        shift_t need;
        code_t  code;
    } map_t;

    // What the encoder hands to the result stage for one byte
    typedef struct packed {
        logic  two;
        code_t first_code;
        logic  first_shift;
        code_t second_code;
    } enc_res_t;

    function automatic map_t a2b_map(input char_t c);
        map_t m;
        char_t off;
        m.cased = 1'b0;
        m.need  = SH_UNKNOWN;
        m.code  = CODE_NONE;
        off     = '0;
        if (c inside {["0":"9"]}) begin
            off    = c - 8'h30;
            m.code = DIGIT_CODES[off[3:0]];
            m.cased = 1'b1;
            m.need  = SH_FIGURES;
        end
        else if (c inside {["A":"Z"]}) begin
            off    = c - 8'h41;
            m.code = ALPHA_CODES[off[4:0]];
            m.cased = 1'b1;
            m.need  = SH_LETTERS;
        end
        else if (c inside {["a":"z"]}) begin
            off    = c - 8'h61;
            m.code = ALPHA_CODES[off[4:0]];
            m.cased = 1'b1;
            m.need  = SH_LETTERS;
        end
        else begin
            // figures-case punctuation and case-free characters
            m.cased = 1'b1;
            m.need  = SH_FIGURES;
            case (c)
                8'h2C: m.code = 5'd12;  // ,
                8'h2E: m.code = 5'd28;  // .
                8'h3A: m.code = 5'd14;  // :
                8'h3B: m.code = 5'd30;  // ;
                8'h22: m.code = 5'd17;  // "
                8'h21: m.code = 5'd13;  // !
                8'h2F: m.code = 5'd29;  // /
                8'h2D: m.code = 5'd3;   // -
                8'h27: m.code = 5'd11;  // '
                8'h28: m.code = 5'd15;  // (
                8'h29: m.code = 5'd18;  // )
                8'h26: m.code = 5'd26;  // &
                8'h23: m.code = 5'd20;  // #
                8'h3F: m.code = 5'd25;  // ?
                8'h20:
                begin
                    m.cased = 1'b0;
                    m.code  = CODE_SPACE;
                end
                8'h0D:
                begin
                    m.cased = 1'b0;
                    m.code  = CODE_CR;
                end
                8'h0A:
                begin
                    m.cased = 1'b0;
                    m.code  = CODE_LF;
                end
                default:
                begin
                    // NUL and unmapped bytes
                    m.cased = 1'b0;
                    m.code  = CODE_NONE;
                end
            endcase
        end
        return m;
    endfunction

endpackage

// File: sv/a2b_in_stage.sv
// Input register for the Baudot encoder: holds one accepted byte until the
// result stage takes it. Depends on a2b_pkg.

module a2b_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  a2b_pkg::char_t ascii_char,
    input  logic           advance,
    output logic           item_valid,
    output a2b_pkg::char_t item_char
);
    import a2b_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    char_t char_reg;
    logic  accept;

    // Take a new byte whenever the held one moves on or none is held
    assign in_stall = valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg <= ascii_char;
        end
    end

    assign item_valid = valid_reg;
    assign item_char  = char_reg;

endmodule

// File: sv/a2b_encode.sv
// Character mapping and shift state for the Baudot encoder. Decides whether
// a shift code goes first. Depends on a2b_pkg.

module a2b_encode (
    input  logic             clk,
    input  logic             rst_n,
    input  a2b_pkg::char_t   item_char,
    input  logic             advance,
    output a2b_pkg::enc_res_t res
);
    import a2b_pkg::*;

    shift_t shift_reg;
    shift_t shift_next;
    map_t   m;

    // Lookup and shift decision
    always_comb
    begin
        m               = a2b_map(item_char);
        res.two         = m.cased && (shift_reg != m.need);
        res.first_code  = m.code;
        res.first_shift = 1'b0;
        res.second_code = m.code;
        if (res.two)
        begin
            res.first_code  = (m.need == SH_LETTERS) ? CODE_LTRS : CODE_FIGS;
            res.first_shift = 1'b1;
        end
        shift_next = shift_reg;
        if (advance && res.two)
        begin
            shift_next = m.need;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= SH_UNKNOWN;
        end
        else
        begin
            shift_reg <= shift_next;
        end
    end

endmodule

// File: sv/a2b_out_stage.sv
// Result register for the Baudot encoder, with a holding slot for the
// character code that follows an inserted shift. Depends on a2b_pkg.

module a2b_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  a2b_pkg::enc_res_t res,
    output logic              advance,
    output logic              out_valid,
    input  logic              out_stall,
    output a2b_pkg::code_t    baudot_code,
    output logic              is_shift,
    output logic              last_of_run
);
    import a2b_pkg::*;

    logic  out_valid_reg;
    logic  out_valid_next;
    logic  pend_valid_reg;
    logic  pend_valid_next;
    code_t pend_code_reg;
    code_t code_reg;
    logic  shift_flag_reg;
    logic  last_reg;
    logic  out_take;
    logic  load_pend;

    assign out_take  = out_valid_reg && !out_stall;
    // A new byte enters only when no second code is still queued
    assign advance   = item_valid && !pend_valid_reg && (!out_valid_reg || !out_stall);
    assign load_pend = !advance && out_take && pend_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        pend_valid_next = pend_valid_reg;
        if (advance)
        begin
            out_valid_next  = 1'b1;
            pend_valid_next = res.two;
        end
        else if (out_take)
        begin
            out_valid_next  = pend_valid_reg;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            code_reg       <= res.first_code;
            shift_flag_reg <= res.first_shift;
            last_reg       <= !res.two;
            pend_code_reg  <= res.second_code;
        end
        else if (load_pend)
        begin
            code_reg       <= pend_code_reg;
            shift_flag_reg <= 1'b0;
            last_reg       <= 1'b1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign baudot_code = code_reg;
    assign is_shift    = shift_flag_reg;
    assign last_of_run = last_reg;

endmodule

// File: sv/ascii_to_baudot_shift_encoder.sv
// Top level of the ASCII to ITA2 Baudot encoder.
// Depends on a2b_pkg, a2b_in_stage, a2b_encode and a2b_out_stage.

// Takes one ASCII byte per transfer and gives one or two 5-bit ITA2 codes.
// A byte whose case differs from the current shift state (unknown after
// reset) first gives a letters (31) or figures (27) shift with is_shift set,
// then the character code; last_of_run marks the final code of each byte.
// A byte goes from the input register through the combinational lookup
// into the output register; bytes needing no shift go at one byte per cycle
// while out_stall is low. A byte that needs a shift holds off the next while
// its trailing code waits in the single output register's one-entry slot.

module ascii_to_baudot_shift_encoder (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  a2b_pkg::char_t ascii_char,
    output logic           out_valid,
    input  logic           out_stall,
    output a2b_pkg::code_t baudot_code,
    output logic           is_shift,
    output logic           last_of_run
);
    import a2b_pkg::*;

    logic     advance;
    logic     item_valid;
    char_t    item_char;
    enc_res_t res;

    a2b_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .ascii_char (ascii_char),
        .advance    (advance),
        .item_valid (item_valid),
        .item_char  (item_char)
    );

    a2b_encode u_enc (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_char (item_char),
        .advance   (advance),
        .res       (res)
    );

    a2b_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .res         (res),
        .advance     (advance),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .baudot_code (baudot_code),
        .is_shift    (is_shift),
        .last_of_run (last_of_run)
    );

endmodule

// File: sv/a2b_checker.sv
// Port-level checks for the Baudot encoder, bound to the top level.
// Depends on a2b_pkg.

module a2b_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           out_valid,
    input logic           out_stall,
    input a2b_pkg::code_t baudot_code,
    input logic           is_shift,
    input logic           last_of_run
);
    import a2b_pkg::*;

    // A shift code is never the last code of a byte
    a_shift_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_shift |-> !last_of_run)
        else $error("shift code marked last of run");

    // Only the two shift codes may carry the shift flag
    a_shift_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_shift |-> (baudot_code == CODE_LTRS || baudot_code == CODE_FIGS))
        else $error("shift flag on a non-shift code");

    // The character code follows its shift straight after the transfer
    a_shift_followed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && is_shift |=> out_valid && !is_shift && last_of_run)
        else $error("shift not followed by its character code");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(baudot_code)
            && $stable(is_shift) && $stable(last_of_run))
        else $error("stalled result changed");

endmodule

bind ascii_to_baudot_shift_encoder a2b_checker u_a2b_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .baudot_code (baudot_code),
    .is_shift    (is_shift),
    .last_of_run (last_of_run)
);

// File: tb/sv/ascii_to_baudot_shift_encoder_tb.sv
// Testbench for ascii_to_baudot_shift_encoder: drives ASCII bytes, predicts the
// ITA2 codes with its own shift-state tracker and checks every output transfer.
// Depends on a2b_pkg (types and shift/code constants) and the encoder RTL.
`timescale 1ns / 1ps

module ascii_to_baudot_shift_encoder_tb;
    import a2b_pkg::*;

    // One expected output code
    typedef struct packed {
        code_t code;
        logic  shift;
        logic  last;
    } ita2_res_t;

    // ITA2 character tables (US teleprinter variant)
    localparam code_t DIGIT_ITA2 [10] = '{
        5'd22, 5'd23, 5'd19, 5'd1, 5'd10, 5'd16, 5'd21, 5'd7, 5'd6, 5'd24
    };
    localparam code_t LETTER_ITA2 [26] = '{
        5'd3,  5'd25, 5'd14, 5'd9,  5'd1,  5'd13, 5'd26, 5'd20, 5'd6,
        5'd11, 5'd15, 5'd18, 5'd28, 5'd12, 5'd24, 5'd22, 5'd23, 5'd10,
        5'd5,  5'd16, 5'd7,  5'd30, 5'd19, 5'd29, 5'd21, 5'd17
    };
    // Figures-case punctuation: , . : ; " ! / - ' ( ) & # ?
    localparam char_t PUNCT_CHARS [14] = '{
        8'h2C, 8'h2E, 8'h3A, 8'h3B, 8'h22, 8'h21, 8'h2F,
        8'h2D, 8'h27, 8'h28, 8'h29, 8'h26, 8'h23, 8'h3F
    };
    localparam char_t CHR_NUL   = 8'h00;
    localparam char_t CHR_LF    = 8'h0A;
    localparam char_t CHR_CR    = 8'h0D;
    localparam char_t CHR_SPACE = 8'h20;

    logic  clk        = 1'b0;
    logic  rst_n      = 1'b0;
    logic  in_valid   = 1'b0;
    logic  in_stall;
    char_t ascii_char = '0;
    logic  out_valid;
    logic  out_stall  = 1'b0;
    code_t baudot_code;
    logic  is_shift;
    logic  last_of_run;

    shift_t    line_shift = SH_UNKNOWN;
    ita2_res_t expected_codes [$];
    int        error_count    = 0;
    int        chars_sent     = 0;
    int        codes_checked  = 0;
    int        shifts_checked = 0;
    logic      idle_on  = 1'b1;
    logic      hold_off = 1'b0;

    ascii_to_baudot_shift_encoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .ascii_char  (ascii_char),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .baudot_code (baudot_code),
        .is_shift    (is_shift),
        .last_of_run (last_of_run)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Hard stop in case the handshake locks up
    initial
    begin
        #3_000_000;
        $display("Timeout: %0d codes still outstanding", expected_codes.size());
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    // Track the line's shift state and queue the codes one byte should produce
    function automatic void predict_codes(input char_t c);
        code_t  cc;
        shift_t need;
        logic   cased;
        char_t  off;
        cc    = CODE_NONE;
        need  = SH_FIGURES;
        cased = 1'b1;
        off   = '0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            off = c - 8'h30;
            cc  = DIGIT_ITA2[off[3:0]];
        end
        else if (c >= 8'h41 && c <= 8'h5A)
        begin
            off  = c - 8'h41;
            cc   = LETTER_ITA2[off[4:0]];
            need = SH_LETTERS;
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            off  = c - 8'h61;
            cc   = LETTER_ITA2[off[4:0]];
            need = SH_LETTERS;
        end
        else
        begin
            case (c)
                8'h2C: cc = 5'd12;
                8'h2E: cc = 5'd28;
                8'h3A: cc = 5'd14;
                8'h3B: cc = 5'd30;
                8'h22: cc = 5'd17;
                8'h21: cc = 5'd13;
                8'h2F: cc = 5'd29;
                8'h2D: cc = 5'd3;
                8'h27: cc = 5'd11;
                8'h28: cc = 5'd15;
                8'h29: cc = 5'd18;
                8'h26: cc = 5'd26;
                8'h23: cc = 5'd20;
                8'h3F: cc = 5'd25;
                CHR_SPACE:
                begin
                    cased = 1'b0;
                    cc    = CODE_SPACE;
                end
                CHR_CR:
                begin
                    cased = 1'b0;
                    cc    = CODE_CR;
                end
                CHR_LF:
                begin
                    cased = 1'b0;
                    cc    = CODE_LF;
                end
                // NUL and unmapped bytes give code 0, state untouched
                default: cased = 1'b0;
            endcase
        end
        // unknown state never matches, so the first cased byte always shifts
        if (cased && line_shift != need)
        begin
            line_shift = need;
            expected_codes.push_back(
                '{(need == SH_LETTERS) ? CODE_LTRS : CODE_FIGS, 1'b1, 1'b0});
        end
        expected_codes.push_back('{cc, 1'b0, 1'b1});
    endfunction

    // Compare one output transfer with the oldest expected code
    task automatic check_code();
        ita2_res_t exp_res;
        if (expected_codes.size() == 0)
        begin
            report_mismatch($sformatf("unexpected code %0d shift %0b last %0b",
                                      baudot_code, is_shift, last_of_run));
            return;
        end
        exp_res = expected_codes.pop_front();
        codes_checked++;
        if (is_shift === 1'b1)
            shifts_checked++;
        if (baudot_code !== exp_res.code)
            report_mismatch($sformatf("code #%0d: baudot_code %0d, expected %0d",
                                      codes_checked, baudot_code, exp_res.code));
        if (is_shift !== exp_res.shift)
            report_mismatch($sformatf("code #%0d: is_shift %b, expected %b",
                                      codes_checked, is_shift, exp_res.shift));
        if (last_of_run !== exp_res.last)
            report_mismatch($sformatf("code #%0d: last_of_run %b, expected %b",
                                      codes_checked, last_of_run, exp_res.last));
    endtask

    // Output side: check each transfer, then pick next cycle's stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_code();
        out_stall <= hold_off || (idle_on && $urandom_range(99) < 21);
    end

    // Offer one byte, with an optional random gap, and wait for the transfer
    task automatic send_char(input char_t c);
        while (idle_on && $urandom_range(99) < 21)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        ascii_char <= c;
        do
            @(posedge clk);
        while (in_stall);
        predict_codes(c);
        chars_sent++;
    endtask

    // Stop offering bytes and let every queued code come out
    task automatic drain_codes();
        in_valid <= 1'b0;
        while (expected_codes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic char_t letter_char();
        return char_t'(8'h41 + $urandom_range(25) + ($urandom_range(1) ? 8'h20 : 8'h00));
    endfunction

    function automatic char_t figure_char();
        if ($urandom_range(3) == 0)
            return PUNCT_CHARS[4'($urandom_range(13))];
        return char_t'(8'h30 + $urandom_range(9));
    endfunction

    function automatic char_t separator_char();
        case ($urandom_range(5))
            0:       return CHR_CR;
            1:       return CHR_LF;
            2:       return PUNCT_CHARS[4'($urandom_range(13))];
            default: return CHR_SPACE;
        endcase
    endfunction

    // Extremes, both shift directions, every case-free byte and unmapped bytes
    task automatic test_directed();
        char_t seq [$];
        seq = '{CHR_NUL, CHR_SPACE, 8'hFF, 8'h61, 8'h5A, 8'h6D, 8'h34, 8'h30,
                8'h39, 8'h27, 8'h3F, 8'h2D, CHR_CR, CHR_LF, 8'h80, 8'h41,
                8'h26, 8'h62, 8'h7F, 8'h2C, 8'h40, 8'h7A, 8'h60, 8'h5B};
        foreach (seq[i])
            send_char(seq[i]);
        drain_codes();
    endtask

    // Text-like words of one case with separators, plus raw noise bytes
    task automatic test_random_text(input int n_chars);
        int sent;
        int kind;
        int run_len;
        sent = 0;
        while (sent < n_chars)
        begin
            kind = $urandom_range(99);
            if (kind < 15)
            begin
                send_char(char_t'($urandom_range(255)));
                sent++;
            end
            else
            begin
                run_len = $urandom_range(8, 1);
                repeat (run_len)
                begin
                    // occasional case change inside a word
                    if ((kind < 60) ^ ($urandom_range(9) == 0))
                        send_char(letter_char());
                    else
                        send_char(figure_char());
                    sent++;
                end
                send_char(separator_char());
                sent++;
            end
        end
        drain_codes();
    endtask

    // Back-to-back transfers with no idling on either side
    task automatic test_steady_stream(input int n_chars);
        idle_on <= 1'b0;
        @(posedge clk);
        repeat (n_chars)
        begin
            if ($urandom_range(1))
                send_char(letter_char());
            else
                send_char(figure_char());
        end
        drain_codes();
        idle_on <= 1'b1;
        @(posedge clk);
    endtask

    // Receiver holds off for a long stretch while bytes keep coming
    task automatic test_output_hold();
        idle_on <= 1'b0;
        fork
            begin
                hold_off <= 1'b1;
                repeat (250) @(posedge clk);
                hold_off <= 1'b0;
            end
        join_none
        @(posedge clk);
        repeat (40)
        begin
            if ($urandom_range(1))
                send_char(letter_char());
            else
                send_char(figure_char());
        end
        drain_codes();
        idle_on <= 1'b1;
        @(posedge clk);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_text(1200);
        test_steady_stream(200);
        test_output_hold();
        $display("Summary: %0d bytes sent, %0d codes checked, %0d shift codes, %0d mismatches",
                 chars_sent, codes_checked, shifts_checked, error_count);
        $display("Covered every byte class, random idling, a steady stream and a long hold-off");
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: ascii_to_baudot_shift_encoder.f
sv/a2b_pkg.sv
sv/a2b_in_stage.sv
sv/a2b_encode.sv
sv/a2b_out_stage.sv
sv/ascii_to_baudot_shift_encoder.sv
sv/a2b_checker.sv
tb/sv/ascii_to_baudot_shift_encoder_tb.sv
